// ===== hdl/slp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the slew limit projection block.
// No dependencies; the front, square root, divide and top files import this package.
package slp_pkg;

    localparam int AXIS_CNT   = 3;   // axis fields carried on the item
    localparam int LIMIT_BITS = 23;  // width of both limit registers
    localparam int Q_BITS     = 23;  // scaled magnitude never exceeds the limit
    localparam int ADDR_BITS  = 4;   // four registers at byte addresses 0..12
    localparam int DATA_BITS  = 32;

    // register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_MODE = 2'd0,
        REG_AXES = 2'd1,
        REG_PLIM = 2'd2,
        REG_CLIM = 2'd3
    } slp_reg_t;

    // control that travels beside the data through every stage
    typedef struct packed {
        logic valid;   // stage holds an item
        logic use_q;   // norm mode and the vector is over the limit
        logic viol;    // free point broke the check limit
    } slp_ctl_t;

endpackage

// ===== hdl/slp_if.sv =====
`timescale 1ns / 1ps
// Item channels of the slew limit projection block: point in, point out.
// Valid/ready handshake; standalone, no package needed.
interface slp_in_if #(parameter int VALUE_BITS = 24);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] axis_value_0;
    logic signed [VALUE_BITS-1:0] axis_value_1;
    logic signed [VALUE_BITS-1:0] axis_value_2;
    logic                         point_is_free;

    modport source (output valid, axis_value_0, axis_value_1, axis_value_2,
                    point_is_free, input ready);
    modport sink   (input valid, axis_value_0, axis_value_1, axis_value_2,
                    point_is_free, output ready);
endinterface

interface slp_out_if #(parameter int VALUE_BITS = 24);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] limited_value_0;
    logic signed [VALUE_BITS-1:0] limited_value_1;
    logic signed [VALUE_BITS-1:0] limited_value_2;
    logic                         bound_violated;

    modport source (output valid, limited_value_0, limited_value_1, limited_value_2,
                    bound_violated, input ready);
    modport sink   (input valid, limited_value_0, limited_value_1, limited_value_2,
                    bound_violated, output ready);
endinterface

// ===== hdl/slp_front.sv =====
`timescale 1ns / 1ps
// Front end: magnitudes and masking, squares, sum of squares and limit compares.
// Three register stages. Depends on slp_pkg.
module slp_front #(
    parameter int VALUE_BITS = 24,
    parameter int MAX_AXES   = 3
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  logic                                in_valid,
    input  logic [VALUE_BITS-1:0]               axis [slp_pkg::AXIS_CNT],
    input  logic                                is_free,
    input  logic                                per_axis_mode,
    input  logic [1:0]                          num_axes,
    input  logic [slp_pkg::LIMIT_BITS-1:0]      plim,
    input  logic [slp_pkg::LIMIT_BITS-1:0]      clim,
    output slp_pkg::slp_ctl_t                   ctl,
    output logic [2*VALUE_BITS+1:0]             sum,
    output logic [VALUE_BITS-1:0]               mag [slp_pkg::AXIS_CNT],
    output logic                                neg [slp_pkg::AXIS_CNT]
);
    import slp_pkg::*;

    localparam int SW   = 2 * VALUE_BITS + 2;
    localparam int LSQ  = 2 * LIMIT_BITS;
    localparam int CW   = (VALUE_BITS > LIMIT_BITS) ? VALUE_BITS : LIMIT_BITS;
    localparam int CMPW = (SW > LSQ) ? SW : LSQ;

    // stage A: sign and magnitude, inactive axes forced to zero
    logic                    a_valid_reg;
    logic                    a_free_reg;
    logic [VALUE_BITS-1:0]   a_mag_reg [AXIS_CNT];
    logic                    a_neg_reg [AXIS_CNT];

    // stage B: squares, clamp, per-axis check
    logic                    b_valid_reg;
    logic                    b_free_reg;
    logic                    b_pviol_reg;
    logic [2*VALUE_BITS-1:0] b_sq_reg [AXIS_CNT];
    logic [LSQ-1:0]          b_plim_sq_reg;
    logic [LSQ-1:0]          b_clim_sq_reg;
    logic [VALUE_BITS-1:0]   b_mag_reg [AXIS_CNT];
    logic                    b_neg_reg [AXIS_CNT];

    // stage C: sum and norm compares
    slp_ctl_t                c_ctl_reg;
    logic [SW-1:0]           c_sum_reg;
    logic [VALUE_BITS-1:0]   c_mag_reg [AXIS_CNT];
    logic                    c_neg_reg [AXIS_CNT];

    logic                    act   [AXIS_CNT];
    logic [VALUE_BITS-1:0]   mag_a [AXIS_CNT];
    logic [VALUE_BITS-1:0]   mag_b [AXIS_CNT];
    logic                    over_c [AXIS_CNT];
    logic                    pviol;
    logic [SW-1:0]           sum_c;
    logic                    scale_c;
    logic                    nviol_c;

    always_comb
    begin
        pviol = 1'b0;
        for (int a = 0; a < AXIS_CNT; a++)
        begin
            act[a]   = (a < MAX_AXES) && (2'(a) < num_axes);
            mag_a[a] = axis[a][VALUE_BITS-1] ? (~axis[a] + 1'b1) : axis[a];
            over_c[a] = CW'(a_mag_reg[a]) > CW'(clim);
            mag_b[a]  = (CW'(a_mag_reg[a]) > CW'(plim)) ? VALUE_BITS'(plim) : a_mag_reg[a];
            pviol     = pviol | over_c[a];
        end
        sum_c   = SW'(b_sq_reg[0]) + SW'(b_sq_reg[1]) + SW'(b_sq_reg[2]);
        scale_c = CMPW'(sum_c) > CMPW'(b_plim_sq_reg);
        nviol_c = CMPW'(sum_c) > CMPW'(b_clim_sq_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_ctl_reg   <= '0;
        end
        else if (adv)
        begin
            a_valid_reg     <= in_valid;
            b_valid_reg     <= a_valid_reg;
            c_ctl_reg.valid <= b_valid_reg;
            c_ctl_reg.use_q <= !per_axis_mode && scale_c;
            c_ctl_reg.viol  <= b_free_reg && (per_axis_mode ? b_pviol_reg : nviol_c);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_free_reg    <= is_free;
            b_free_reg    <= a_free_reg;
            b_pviol_reg   <= pviol;
            b_plim_sq_reg <= plim * plim;
            b_clim_sq_reg <= clim * clim;
            c_sum_reg     <= sum_c;
            for (int a = 0; a < AXIS_CNT; a++)
            begin
                a_mag_reg[a] <= act[a] ? mag_a[a] : '0;
                a_neg_reg[a] <= act[a] && axis[a][VALUE_BITS-1];
                b_sq_reg[a]  <= a_mag_reg[a] * a_mag_reg[a];
                b_mag_reg[a] <= per_axis_mode ? mag_b[a] : a_mag_reg[a];
                b_neg_reg[a] <= a_neg_reg[a];
                c_mag_reg[a] <= b_mag_reg[a];
                c_neg_reg[a] <= b_neg_reg[a];
            end
        end
    end

    assign ctl = c_ctl_reg;
    assign sum = c_sum_reg;
    always_comb
    begin
        for (int a = 0; a < AXIS_CNT; a++)
        begin
            mag[a] = c_mag_reg[a];
            neg[a] = c_neg_reg[a];
        end
    end

endmodule

// ===== hdl/slp_isqrt.sv =====
`timescale 1ns / 1ps
// Pipelined integer floor square root, one root bit per stage.
// Carries the axis data alongside. Depends on slp_pkg.
module slp_isqrt #(
    parameter int VALUE_BITS = 24
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  slp_pkg::slp_ctl_t         in_ctl,
    input  logic [2*VALUE_BITS+1:0]   in_sum,
    input  logic [VALUE_BITS-1:0]     in_mag [slp_pkg::AXIS_CNT],
    input  logic                      in_neg [slp_pkg::AXIS_CNT],
    output slp_pkg::slp_ctl_t         out_ctl,
    output logic [VALUE_BITS:0]       out_root,
    output logic [VALUE_BITS-1:0]     out_mag [slp_pkg::AXIS_CNT],
    output logic                      out_neg [slp_pkg::AXIS_CNT]
);
    import slp_pkg::*;

    localparam int R = VALUE_BITS + 1;
    localparam int S = 2 * R;

    slp_ctl_t              ctl_reg  [R];
    logic [S-1:0]          rem_reg  [R];
    logic [R-1:0]          root_reg [R];
    logic [VALUE_BITS-1:0] mag_reg  [R][AXIS_CNT];
    logic                  neg_reg  [R][AXIS_CNT];

    for (genvar g = 0; g < R; g++)
    begin : g_stage
        localparam int K = R - 1 - g;                 // root bit decided here
        localparam int P = (g == 0) ? 0 : g - 1;      // previous stage

        slp_ctl_t              ctl_p;
        logic [S-1:0]          rem_p;
        logic [R-1:0]          root_p;
        logic [VALUE_BITS-1:0] mag_p [AXIS_CNT];
        logic                  neg_p [AXIS_CNT];
        logic [S-1:0]          trial;
        logic                  take;

        always_comb
        begin
            if (g == 0)
            begin
                ctl_p  = in_ctl;
                rem_p  = in_sum;
                root_p = '0;
                for (int a = 0; a < AXIS_CNT; a++)
                begin
                    mag_p[a] = in_mag[a];
                    neg_p[a] = in_neg[a];
                end
            end
            else
            begin
                ctl_p  = ctl_reg[P];
                rem_p  = rem_reg[P];
                root_p = root_reg[P];
                for (int a = 0; a < AXIS_CNT; a++)
                begin
                    mag_p[a] = mag_reg[P][a];
                    neg_p[a] = neg_reg[P][a];
                end
            end
            // (2*root + 2^K) * 2^K, root holds only bits above K
            trial = (S'(root_p) << (K + 1)) | (S'(1) << (2 * K));
            take  = rem_p >= trial;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[g] <= '0;
            end
            else if (adv)
            begin
                ctl_reg[g] <= ctl_p;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[g]  <= take ? (rem_p - trial) : rem_p;
                root_reg[g] <= take ? (root_p | (R'(1) << K)) : root_p;
                for (int a = 0; a < AXIS_CNT; a++)
                begin
                    mag_reg[g][a] <= mag_p[a];
                    neg_reg[g][a] <= neg_p[a];
                end
            end
        end
    end

    assign out_ctl  = ctl_reg[R-1];
    assign out_root = root_reg[R-1];
    always_comb
    begin
        for (int a = 0; a < AXIS_CNT; a++)
        begin
            out_mag[a] = mag_reg[R-1][a];
            out_neg[a] = neg_reg[R-1][a];
        end
    end

endmodule

// ===== hdl/slp_divide.sv =====
`timescale 1ns / 1ps
// Scaling: mag * limit, pipelined restoring division by the root, sign and select.
// Last stage is the output register. Depends on slp_pkg.
module slp_divide #(
    parameter int VALUE_BITS = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  logic [slp_pkg::LIMIT_BITS-1:0]    plim,
    input  slp_pkg::slp_ctl_t                 in_ctl,
    input  logic [VALUE_BITS:0]               in_root,
    input  logic [VALUE_BITS-1:0]             in_mag [slp_pkg::AXIS_CNT],
    input  logic                              in_neg [slp_pkg::AXIS_CNT],
    output logic                              out_valid,
    output logic                              out_viol,
    output logic [VALUE_BITS-1:0]             out_value [slp_pkg::AXIS_CNT]
);
    import slp_pkg::*;

    localparam int R  = VALUE_BITS + 1;
    localparam int DW = VALUE_BITS + LIMIT_BITS;
    localparam int CW = (VALUE_BITS > Q_BITS) ? VALUE_BITS : Q_BITS;

    // product stage
    slp_ctl_t              p_ctl_reg;
    logic [R-1:0]          p_root_reg;
    logic [DW-1:0]         p_prod_reg [AXIS_CNT];
    logic [VALUE_BITS-1:0] p_mag_reg  [AXIS_CNT];
    logic                  p_neg_reg  [AXIS_CNT];

    // division stages, quotient bit Q_BITS-1-j decided in stage j
    slp_ctl_t              ctl_reg  [Q_BITS];
    logic [R-1:0]          root_reg [Q_BITS];
    logic [DW-1:0]         rem_reg  [Q_BITS][AXIS_CNT];
    logic [Q_BITS-1:0]     quo_reg  [Q_BITS][AXIS_CNT];
    logic [VALUE_BITS-1:0] mag_reg  [Q_BITS][AXIS_CNT];
    logic                  neg_reg  [Q_BITS][AXIS_CNT];

    // output register
    logic                  o_valid_reg;
    logic                  o_viol_reg;
    logic [VALUE_BITS-1:0] o_value_reg [AXIS_CNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_ctl_reg <= '0;
        end
        else if (adv)
        begin
            p_ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_root_reg <= in_root;
            for (int a = 0; a < AXIS_CNT; a++)
            begin
                p_prod_reg[a] <= in_mag[a] * plim;
                p_mag_reg[a]  <= in_mag[a];
                p_neg_reg[a]  <= in_neg[a];
            end
        end
    end

    for (genvar j = 0; j < Q_BITS; j++)
    begin : g_stage
        localparam int I = Q_BITS - 1 - j;
        localparam int P = (j == 0) ? 0 : j - 1;   // previous stage

        slp_ctl_t              ctl_p;
        logic [R-1:0]          root_p;
        logic [DW-1:0]         rem_p  [AXIS_CNT];
        logic [Q_BITS-1:0]     quo_p  [AXIS_CNT];
        logic [VALUE_BITS-1:0] mag_p  [AXIS_CNT];
        logic                  neg_p  [AXIS_CNT];
        logic [DW-1:0]         dsh;
        logic                  take   [AXIS_CNT];

        always_comb
        begin
            if (j == 0)
            begin
                ctl_p  = p_ctl_reg;
                root_p = p_root_reg;
                for (int a = 0; a < AXIS_CNT; a++)
                begin
                    rem_p[a] = p_prod_reg[a];
                    quo_p[a] = '0;
                    mag_p[a] = p_mag_reg[a];
                    neg_p[a] = p_neg_reg[a];
                end
            end
            else
            begin
                ctl_p  = ctl_reg[P];
                root_p = root_reg[P];
                for (int a = 0; a < AXIS_CNT; a++)
                begin
                    rem_p[a] = rem_reg[P][a];
                    quo_p[a] = quo_reg[P][a];
                    mag_p[a] = mag_reg[P][a];
                    neg_p[a] = neg_reg[P][a];
                end
            end
            dsh = DW'(root_p) << I;
            for (int a = 0; a < AXIS_CNT; a++)
            begin
                take[a] = rem_p[a] >= dsh;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[j] <= '0;
            end
            else if (adv)
            begin
                ctl_reg[j] <= ctl_p;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                root_reg[j] <= root_p;
                for (int a = 0; a < AXIS_CNT; a++)
                begin
                    rem_reg[j][a] <= take[a] ? (rem_p[a] - dsh) : rem_p[a];
                    quo_reg[j][a] <= quo_p[a] | (take[a] ? (Q_BITS'(1) << I) : '0);
                    mag_reg[j][a] <= mag_p[a];
                    neg_reg[j][a] <= neg_p[a];
                end
            end
        end
    end

    // select scaled or passed magnitude, then restore the sign
    logic [CW-1:0] sel_mag [AXIS_CNT];
    logic [CW-1:0] signed_v [AXIS_CNT];

    always_comb
    begin
        for (int a = 0; a < AXIS_CNT; a++)
        begin
            sel_mag[a]  = ctl_reg[Q_BITS-1].use_q ? CW'(quo_reg[Q_BITS-1][a])
                                                 : CW'(mag_reg[Q_BITS-1][a]);
            signed_v[a] = neg_reg[Q_BITS-1][a] ? (~sel_mag[a] + 1'b1) : sel_mag[a];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            o_valid_reg <= ctl_reg[Q_BITS-1].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            o_viol_reg <= ctl_reg[Q_BITS-1].viol;
            for (int a = 0; a < AXIS_CNT; a++)
            begin
                o_value_reg[a] <= signed_v[a][VALUE_BITS-1:0];
            end
        end
    end

    assign out_valid = o_valid_reg;
    assign out_viol  = o_viol_reg;
    always_comb
    begin
        for (int a = 0; a < AXIS_CNT; a++)
        begin
            out_value[a] = o_value_reg[a];
        end
    end

endmodule

// ===== hdl/slew_limit_projection.sv =====
`timescale 1ns / 1ps
// Top level of the slew limit projection block: APB registers and the pipeline.
// Depends on slp_pkg, slp_if, slp_front, slp_isqrt, slp_divide.
//
//  channel    | dir | handshake        | carries
//  -----------+-----+------------------+-----------------------------------------
//  point_in   | in  | valid / ready    | axis_value_0..2, point_is_free
//  point_out  | out | valid / ready    | limited_value_0..2, bound_violated
//  APB        | in  | psel/penable     | per_axis_mode, num_axes, both limits
//
// One item per cycle while the pipeline is not held. It has 3 front stages,
// VALUE_BITS+1 square root stages, 1 product stage,
// 23 division stages and the output register.
// Reset clears every stage valid bit and loads the register defaults.
// The whole pipeline advances together; it holds while the output register
// is full and point_out is not ready, so point_in.ready follows that.
module slew_limit_projection #(
    parameter int MAX_AXES   = 3,
    parameter int VALUE_BITS = 24
) (
    input  logic                             clk,
    input  logic                             rst_n,
    slp_in_if.sink                           point_in,
    slp_out_if.source                        point_out,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [slp_pkg::ADDR_BITS-1:0]    paddr,
    input  logic [slp_pkg::DATA_BITS-1:0]    pwdata,
    output logic [slp_pkg::DATA_BITS-1:0]    prdata,
    output logic                             pready
);
    import slp_pkg::*;

    // configuration registers
    logic                  mode_reg;
    logic [1:0]            axes_reg;
    logic [LIMIT_BITS-1:0] plim_reg;
    logic [LIMIT_BITS-1:0] clim_reg;

    slp_reg_t reg_sel;
    logic     wr_en;

    assign reg_sel = slp_reg_t'(paddr[3:2]);
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            axes_reg <= 2'd3;
            plim_reg <= '1;
            clim_reg <= '1;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_MODE: mode_reg <= pwdata[0];
                REG_AXES: axes_reg <= pwdata[1:0];
                REG_PLIM: plim_reg <= pwdata[LIMIT_BITS-1:0];
                REG_CLIM: clim_reg <= pwdata[LIMIT_BITS-1:0];
                default:  mode_reg <= mode_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_MODE: prdata = DATA_BITS'(mode_reg);
            REG_AXES: prdata = DATA_BITS'(axes_reg);
            REG_PLIM: prdata = DATA_BITS'(plim_reg);
            REG_CLIM: prdata = DATA_BITS'(clim_reg);
            default:  prdata = '0;
        endcase
    end

    // global advance: move whenever the output slot is free or being taken
    logic adv;
    assign adv            = !point_out.valid || point_out.ready;
    assign point_in.ready = adv;

    logic [VALUE_BITS-1:0] axis_in [AXIS_CNT];
    assign axis_in[0] = point_in.axis_value_0;
    assign axis_in[1] = point_in.axis_value_1;
    assign axis_in[2] = point_in.axis_value_2;

    slp_ctl_t              f_ctl;
    logic [2*VALUE_BITS+1:0] f_sum;
    logic [VALUE_BITS-1:0] f_mag [AXIS_CNT];
    logic                  f_neg [AXIS_CNT];

    slp_front #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_AXES   (MAX_AXES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .in_valid      (point_in.valid),
        .axis          (axis_in),
        .is_free       (point_in.point_is_free),
        .per_axis_mode (mode_reg),
        .num_axes      (axes_reg),
        .plim          (plim_reg),
        .clim          (clim_reg),
        .ctl           (f_ctl),
        .sum           (f_sum),
        .mag           (f_mag),
        .neg           (f_neg)
    );

    slp_ctl_t              r_ctl;
    logic [VALUE_BITS:0]   r_root;
    logic [VALUE_BITS-1:0] r_mag [AXIS_CNT];
    logic                  r_neg [AXIS_CNT];

    slp_isqrt #(
        .VALUE_BITS (VALUE_BITS)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_ctl   (f_ctl),
        .in_sum   (f_sum),
        .in_mag   (f_mag),
        .in_neg   (f_neg),
        .out_ctl  (r_ctl),
        .out_root (r_root),
        .out_mag  (r_mag),
        .out_neg  (r_neg)
    );

    logic                  d_valid;
    logic                  d_viol;
    logic [VALUE_BITS-1:0] d_value [AXIS_CNT];

    // mag never exceeds floor(sqrt(sum)), so the quotient stays within the limit
    slp_divide #(
        .VALUE_BITS (VALUE_BITS)
    ) u_divide (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .plim      (plim_reg),
        .in_ctl    (r_ctl),
        .in_root   (r_root),
        .in_mag    (r_mag),
        .in_neg    (r_neg),
        .out_valid (d_valid),
        .out_viol  (d_viol),
        .out_value (d_value)
    );

    assign point_out.valid           = d_valid;
    assign point_out.bound_violated  = d_viol;
    assign point_out.limited_value_0 = d_value[0];
    assign point_out.limited_value_1 = d_value[1];
    assign point_out.limited_value_2 = d_value[2];

endmodule
